>>> rtl/swrt_pkg.sv
package swrt_pkg;

	// command codes of an input request
	localparam logic [1:0] CMD_SEGMENT = 2'd0;
	localparam logic [1:0] CMD_PACKET  = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_RETRY   = 2'd1;
	localparam logic [1:0] CFG_START   = 2'd2;

	// reset values
	localparam logic [15:0] TIMEOUT_RESET     = 16'd500;
	localparam logic [3:0]  RETRY_RESET       = 4'd5;
	localparam logic [31:0] START_SEQ_RESET   = 32'd101;
	localparam logic [15:0] PEER_WINDOW_RESET = 16'hFFFF;

	localparam logic [15:0] AGE_MAX    = 16'hFFFF;
	// results one tick may give
	localparam logic [3:0]  RESULT_CAP = 4'd8;

	typedef enum logic [2:0] {
		KIND_SEND        = 3'd0,
		KIND_RESEND      = 3'd1,
		KIND_FULL        = 3'd2,
		KIND_ACK         = 3'd3,
		KIND_IGNORED     = 3'd4,
		KIND_RETRY_FAIL  = 3'd5,
		KIND_FAILED_IDLE = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_CHECK,
		ST_TICK_EVAL,
		ST_ACK_CHECK,
		ST_ACK_EVAL,
		ST_EMIT
	} state_t;

	// one stored segment
	typedef struct packed {
		logic [31:0] seq;
		logic [10:0] len;
		logic [3:0]  retries;
		logic [15:0] age;
	} slot_t;

	// what the slot unit reports on one slot
	typedef struct packed {
		logic        timed_out;
		logic        exhausted;
		logic        outstanding;
		logic [3:0]  retries;
		logic [15:0] age;
	} slot_eval_t;

endpackage

>>> rtl/swrt_cmd_if.sv
interface swrt_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [10:0] segment_length;
	logic        ack_flag;
	logic [31:0] ack_number;
	logic [15:0] advertised_window;

	modport source (
		output valid, command, segment_length, ack_flag, ack_number, advertised_window,
		input  ready
	);
	modport sink (
		input  valid, command, segment_length, ack_flag, ack_number, advertised_window,
		output ready
	);
endinterface

>>> rtl/swrt_res_if.sv
interface swrt_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] segment_sequence;
	logic [10:0] segment_bytes;
	logic [31:0] base_now;
	logic [15:0] peer_window_now;
	logic        all_acked;
	logic        last_of_run;

	modport source (
		output valid, kind, segment_sequence, segment_bytes, base_now, peer_window_now,
		       all_acked, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, kind, segment_sequence, segment_bytes, base_now, peer_window_now,
		       all_acked, last_of_run,
		output ready
	);
endinterface

>>> rtl/swrt_slot_mem.sv
module swrt_slot_mem #(
	parameter int DEPTH  = 8,
	parameter int ADDR_W = 3
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  swrt_pkg::slot_t     wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output swrt_pkg::slot_t     rdata
);

	swrt_pkg::slot_t mem_q [DEPTH];
	swrt_pkg::slot_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while not read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/swrt_slot_unit.sv
module swrt_slot_unit (
	input  swrt_pkg::slot_t      slot,
	input  logic [15:0]          timeout,
	input  logic [3:0]           retry_limit,
	input  logic [31:0]          base_seq,
	input  logic [31:0]          next_seq,
	output swrt_pkg::slot_eval_t result
);

	logic [15:0] age_inc;
	logic [31:0] end_off;
	logic [31:0] span;
	logic        timed_out;
	logic        exhausted;

	// aging with saturation, then timeout and retry checks
	assign age_inc   = (slot.age == swrt_pkg::AGE_MAX) ? slot.age : slot.age + 16'd1;
	assign timed_out = (age_inc >= timeout);
	assign exhausted = (slot.retries >= retry_limit);

	// offset of the last byte past the base (end minus one), against the open span
	assign end_off = slot.seq + {21'd0, slot.len} + ~base_seq;
	assign span    = next_seq - base_seq;

	always_comb begin
		result.timed_out   = timed_out;
		result.exhausted   = exhausted;
		result.outstanding = (end_off < span);
		if (timed_out && !exhausted) begin
			result.age     = 16'd0;
			result.retries = slot.retries + 4'd1;
		end else begin
			result.age     = age_inc;
			result.retries = slot.retries;
		end
	end

endmodule

>>> rtl/sliding_window_retransmit_tracker.sv
// Sender-side sliding window tracker. Segments are admitted while the bytes in flight stay
// below WINDOW_SLOTS * SEGMENT_BYTES and their slot is free, cumulative acks move the window
// base, and ticks age the outstanding segments and resend those that time out, ending in a
// retry failure that blocks all further work until start_sequence is written again. Slot
// records live in a single-port-read memory, and one slot evaluation unit serves both the
// ack and the tick scans. A new segment, a packet without ack, an unknown command or any
// request after a failure goes straight from idle to the emit state. An ack scans all
// WINDOW_SLOTS slots, reading and then evaluating each valid slot and stepping over an
// empty one; a tick scans the same way from the oldest slot and stops early on a retry
// failure or once RESULT_CAP results are given. Results wait in an output register, so
// a stalled result side only delays the request that needs the next result slot.
module sliding_window_retransmit_tracker #(
	parameter int WINDOW_SLOTS  = 8,
	parameter int SEGMENT_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	swrt_cmd_if.sink    cmd,
	swrt_res_if.source  res
);

	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int STEP_W = $clog2(WINDOW_SLOTS + 1);
	localparam logic [31:0]       WINDOW_LIMIT = 32'(WINDOW_SLOTS * SEGMENT_BYTES);
	localparam logic [31:0]       SEG_MAX      = 32'(SEGMENT_BYTES);
	localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(WINDOW_SLOTS - 1);
	localparam logic [STEP_W-1:0] ALL_STEPS    = STEP_W'(WINDOW_SLOTS);

	swrt_pkg::state_t state_q, state_d;

	logic [15:0]             timeout_q;
	logic [3:0]              retry_limit_q;
	logic [31:0]             base_seq_q;
	logic [31:0]             next_seq_q;
	logic [SLOT_W-1:0]       write_slot_q;
	logic [15:0]             peer_window_q;
	logic                    failed_q;
	logic [WINDOW_SLOTS-1:0] valid_q;
	logic [SLOT_W-1:0]       idx_q;
	logic [STEP_W-1:0]       step_q;
	logic [3:0]              count_q;

	logic                    pend_valid_q;
	swrt_pkg::kind_t         pend_kind_q;
	logic [31:0]             pend_seq_q;
	logic [10:0]             pend_bytes_q;

	logic                    res_valid_q;
	swrt_pkg::kind_t         res_kind_q;
	logic [31:0]             res_seq_q;
	logic [10:0]             res_bytes_q;
	logic [31:0]             res_base_q;
	logic [15:0]             res_peer_q;
	logic                    res_all_q;
	logic                    res_last_q;

	logic                    cmd_ready;
	logic                    accept;
	logic                    out_free;
	logic                    cur_valid;
	logic                    scan_done;
	logic                    cap_hit;
	logic                    tick_go;
	logic                    tick_commit;
	logic                    emit_go;
	logic                    push_out;
	logic                    push_last;
	logic                    mem_re;
	logic                    mem_we;
	logic [SLOT_W-1:0]       mem_waddr;
	swrt_pkg::slot_t         mem_wdata;
	swrt_pkg::slot_t         mem_rdata;
	swrt_pkg::slot_eval_t    ev;

	logic                    len_bad;
	logic                    win_full;
	logic                    admit;
	logic [31:0]             in_flight;
	logic [31:0]             ack_ahead;
	logic [31:0]             ack_span;
	logic                    ack_moves;
	logic [SLOT_W-1:0]       idx_next;
	logic [SLOT_W-1:0]       write_slot_next;

	// slot record storage
	swrt_slot_mem #(
		.DEPTH  (WINDOW_SLOTS),
		.ADDR_W (SLOT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	// shared slot evaluation for ticks and acks
	swrt_slot_unit u_unit (
		.slot        (mem_rdata),
		.timeout     (timeout_q),
		.retry_limit (retry_limit_q),
		.base_seq    (base_seq_q),
		.next_seq    (next_seq_q),
		.result      (ev)
	);

	// request checks at acceptance
	assign accept    = cmd.valid && cmd_ready;
	assign in_flight = next_seq_q - base_seq_q;
	assign len_bad   = (cmd.segment_length == 11'd0) || ({21'd0, cmd.segment_length} > SEG_MAX);
	assign win_full  = (in_flight >= WINDOW_LIMIT) || valid_q[write_slot_q];
	assign admit     = !failed_q && (cmd.command == swrt_pkg::CMD_SEGMENT) && !len_bad
	                   && !win_full;
	assign ack_ahead = cmd.ack_number - base_seq_q;
	assign ack_span  = next_seq_q - base_seq_q;
	assign ack_moves = (ack_ahead != 32'd0) && (ack_ahead <= ack_span);

	// scan bookkeeping
	assign out_free        = !res_valid_q || res.ready;
	assign cur_valid       = valid_q[idx_q];
	assign scan_done       = (step_q == ALL_STEPS);
	assign cap_hit         = (count_q >= swrt_pkg::RESULT_CAP);
	assign tick_go         = !ev.timed_out || !pend_valid_q || out_free;
	assign emit_go         = !pend_valid_q || out_free;
	assign idx_next        = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
	assign write_slot_next = (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + 1'b1;

	// memory write: new segment or tick write-back
	assign mem_we    = (accept && admit) || tick_commit;
	assign mem_waddr = (state_q == swrt_pkg::ST_IDLE) ? write_slot_q : idx_q;
	always_comb begin
		if (state_q == swrt_pkg::ST_IDLE) begin
			mem_wdata.seq     = next_seq_q;
			mem_wdata.len     = cmd.segment_length;
			mem_wdata.retries = 4'd0;
			mem_wdata.age     = 16'd0;
		end else begin
			mem_wdata.seq     = mem_rdata.seq;
			mem_wdata.len     = mem_rdata.len;
			mem_wdata.retries = ev.retries;
			mem_wdata.age     = ev.age;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swrt_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (failed_q) begin
						state_d = swrt_pkg::ST_EMIT;
					end else if (cmd.command == swrt_pkg::CMD_TICK) begin
						state_d = swrt_pkg::ST_TICK_CHECK;
					end else if (cmd.command == swrt_pkg::CMD_PACKET && cmd.ack_flag) begin
						state_d = swrt_pkg::ST_ACK_CHECK;
					end else begin
						state_d = swrt_pkg::ST_EMIT;
					end
				end
			end
			swrt_pkg::ST_TICK_CHECK: begin
				priority if (scan_done) begin
					state_d = swrt_pkg::ST_EMIT;
				end else if (!cur_valid) begin
					state_d = swrt_pkg::ST_TICK_CHECK;
				end else if (cap_hit) begin
					state_d = swrt_pkg::ST_EMIT;
				end else begin
					state_d = swrt_pkg::ST_TICK_EVAL;
				end
			end
			swrt_pkg::ST_TICK_EVAL: begin
				if (tick_go) begin
					if (ev.timed_out && ev.exhausted) begin
						state_d = swrt_pkg::ST_EMIT;
					end else begin
						state_d = swrt_pkg::ST_TICK_CHECK;
					end
				end
			end
			swrt_pkg::ST_ACK_CHECK: begin
				priority if (scan_done) begin
					state_d = swrt_pkg::ST_EMIT;
				end else if (!cur_valid) begin
					state_d = swrt_pkg::ST_ACK_CHECK;
				end else begin
					state_d = swrt_pkg::ST_ACK_EVAL;
				end
			end
			swrt_pkg::ST_ACK_EVAL: begin
				state_d = swrt_pkg::ST_ACK_CHECK;
			end
			swrt_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_d = swrt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swrt_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_ready   = 1'b0;
		mem_re      = 1'b0;
		tick_commit = 1'b0;
		push_out    = 1'b0;
		push_last   = 1'b0;
		unique case (state_q)
			swrt_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
			end
			swrt_pkg::ST_TICK_CHECK: begin
				mem_re = !scan_done && cur_valid && !cap_hit;
			end
			swrt_pkg::ST_TICK_EVAL: begin
				tick_commit = tick_go;
				push_out    = ev.timed_out && pend_valid_q && out_free;
			end
			swrt_pkg::ST_ACK_CHECK: begin
				mem_re = !scan_done && cur_valid;
			end
			swrt_pkg::ST_ACK_EVAL: begin
				mem_re = 1'b0;
			end
			swrt_pkg::ST_EMIT: begin
				push_out  = pend_valid_q && out_free;
				push_last = 1'b1;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	// control state, configuration and window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= swrt_pkg::ST_IDLE;
			timeout_q     <= swrt_pkg::TIMEOUT_RESET;
			retry_limit_q <= swrt_pkg::RETRY_RESET;
			base_seq_q    <= swrt_pkg::START_SEQ_RESET;
			next_seq_q    <= swrt_pkg::START_SEQ_RESET;
			write_slot_q  <= '0;
			peer_window_q <= swrt_pkg::PEER_WINDOW_RESET;
			failed_q      <= 1'b0;
			valid_q       <= '0;
			idx_q         <= '0;
			step_q        <= '0;
			count_q       <= '0;
			pend_valid_q  <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					swrt_pkg::CFG_TIMEOUT: timeout_q <= cfg_data[15:0];
					swrt_pkg::CFG_RETRY:   retry_limit_q <= cfg_data[3:0];
					swrt_pkg::CFG_START: begin
						base_seq_q    <= cfg_data;
						next_seq_q    <= cfg_data;
						write_slot_q  <= '0;
						peer_window_q <= swrt_pkg::PEER_WINDOW_RESET;
						failed_q      <= 1'b0;
						valid_q       <= '0;
					end
					default: begin
						failed_q <= failed_q;
					end
				endcase
			end

			// request acceptance
			if (accept) begin
				if (failed_q) begin
					pend_valid_q <= 1'b1;
				end else begin
					unique case (cmd.command)
						swrt_pkg::CMD_SEGMENT: begin
							pend_valid_q <= 1'b1;
							if (admit) begin
								valid_q[write_slot_q] <= 1'b1;
								next_seq_q   <= next_seq_q + {21'd0, cmd.segment_length};
								write_slot_q <= write_slot_next;
							end
						end
						swrt_pkg::CMD_PACKET: begin
							pend_valid_q <= 1'b1;
							if (cmd.ack_flag) begin
								if (ack_moves) begin
									base_seq_q <= cmd.ack_number;
								end
								peer_window_q <= cmd.advertised_window;
								idx_q  <= '0;
								step_q <= '0;
							end
						end
						swrt_pkg::CMD_TICK: begin
							pend_valid_q <= 1'b0;
							idx_q   <= write_slot_q;
							step_q  <= '0;
							count_q <= '0;
						end
						default: begin
							pend_valid_q <= 1'b1;
						end
					endcase
				end
			end

			// scan steps over empty slots
			if ((state_q == swrt_pkg::ST_TICK_CHECK || state_q == swrt_pkg::ST_ACK_CHECK)
			    && !scan_done && !cur_valid) begin
				idx_q  <= idx_next;
				step_q <= step_q + 1'b1;
			end

			// tick evaluation of one slot
			if (tick_commit) begin
				if (ev.timed_out) begin
					pend_valid_q <= 1'b1;
					count_q      <= count_q + 4'd1;
				end
				if (ev.timed_out && ev.exhausted) begin
					failed_q <= 1'b1;
				end else begin
					idx_q  <= idx_next;
					step_q <= step_q + 1'b1;
				end
			end

			// ack evaluation of one slot
			if (state_q == swrt_pkg::ST_ACK_EVAL) begin
				if (!ev.outstanding) begin
					valid_q[idx_q] <= 1'b0;
				end
				idx_q  <= idx_next;
				step_q <= step_q + 1'b1;
			end

			// final result handed to the output register
			if (state_q == swrt_pkg::ST_EMIT && push_out) begin
				pend_valid_q <= 1'b0;
			end

			// output register handshake
			if (push_out) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// pending result payload, segment fields only on a send, a resend or a retry failure
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_seq_q   <= admit ? next_seq_q : '0;
			pend_bytes_q <= admit ? cmd.segment_length : '0;
			if (failed_q) begin
				pend_kind_q <= swrt_pkg::KIND_FAILED_IDLE;
			end else if (cmd.command == swrt_pkg::CMD_SEGMENT) begin
				priority if (len_bad) begin
					pend_kind_q <= swrt_pkg::KIND_IGNORED;
				end else if (win_full) begin
					pend_kind_q <= swrt_pkg::KIND_FULL;
				end else begin
					pend_kind_q <= swrt_pkg::KIND_SEND;
				end
			end else if (cmd.command == swrt_pkg::CMD_PACKET && cmd.ack_flag) begin
				pend_kind_q <= swrt_pkg::KIND_ACK;
			end else begin
				pend_kind_q <= swrt_pkg::KIND_IGNORED;
			end
		end else if (tick_commit && ev.timed_out) begin
			pend_kind_q  <= ev.exhausted ? swrt_pkg::KIND_RETRY_FAIL : swrt_pkg::KIND_RESEND;
			pend_seq_q   <= mem_rdata.seq;
			pend_bytes_q <= mem_rdata.len;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (push_out) begin
			res_kind_q  <= pend_kind_q;
			res_seq_q   <= pend_seq_q;
			res_bytes_q <= pend_bytes_q;
			res_base_q  <= base_seq_q;
			res_peer_q  <= peer_window_q;
			res_all_q   <= (base_seq_q == next_seq_q);
			res_last_q  <= push_last;
		end
	end

	assign cmd.ready            = cmd_ready;
	assign res.valid            = res_valid_q;
	assign res.kind             = res_kind_q;
	assign res.segment_sequence = res_seq_q;
	assign res.segment_bytes    = res_bytes_q;
	assign res.base_now         = res_base_q;
	assign res.peer_window_now  = res_peer_q;
	assign res.all_acked        = res_all_q;
	assign res.last_of_run      = res_last_q;

endmodule

>>> rtl/swrt_checker.sv
module swrt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  res_kind,
	input logic [31:0] res_seq,
	input logic [10:0] res_bytes,
	input logic        res_all_acked,
	input logic        res_last
);

	// a stalled result holds its contents
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_seq)
		&& $stable(res_bytes))
		else $error("result changed while stalled");

	// every accepted request makes the block busy, so no request is taken back to back
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("request taken back to back");

	// a send is a single result and leaves bytes in flight
	a_send_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == swrt_pkg::KIND_SEND |-> res_last && !res_all_acked
		&& res_bytes != 11'd0)
		else $error("malformed send result");

	// results without a segment carry no segment and end their run
	a_empty_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == swrt_pkg::KIND_FULL || res_kind == swrt_pkg::KIND_ACK
		|| res_kind == swrt_pkg::KIND_IGNORED || res_kind == swrt_pkg::KIND_FAILED_IDLE)
		|-> res_last && res_seq == 32'd0 && res_bytes == 11'd0)
		else $error("segment fields set on a result without segment");

endmodule

bind sliding_window_retransmit_tracker swrt_checker u_swrt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_kind      (res.kind),
	.res_seq       (res.segment_sequence),
	.res_bytes     (res.segment_bytes),
	.res_all_acked (res.all_acked),
	.res_last      (res.last_of_run)
);
